// ===== src/lfu_kvc_pkg.sv =====
package lfu_kvc_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CNT_W = 32;
	localparam int CAP_W = 5;
	localparam int OCC_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
	localparam logic [CAP_W-1:0] CAP_MAX    = 5'd31;
	localparam logic [CNT_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;
	localparam logic [CNT_W-1:0] COUNT_ONE  = 32'd1;
	localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic                    opcode;
		logic signed [KEY_W-1:0] lookup_key;
		logic signed [VAL_W-1:0] store_value;
	} req_t;

	typedef struct packed {
		logic                    hit;
		logic signed [VAL_W-1:0] read_value;
		logic                    evicted;
		logic signed [KEY_W-1:0] evicted_key;
	} rsp_t;

	typedef struct packed {
		logic                    valid;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
		logic [CNT_W-1:0]        count;
	} entry_t;

endpackage

// ===== src/lfu_kvc_ram.sv =====
module lfu_kvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/lfu_key_value_cache.sv =====
// LFU key/value cache. One request is taken when start is high and busy is low; its
// response appears on response after the scan and the write-back, marked by a one-cycle
// done strobe, and a new request may be started in that same cycle. The response cannot
// be held off. Each request reads every slot of the entry memory once through its single
// read port, then makes the decision and write-back in the write state and returns to idle
// to take the next request, so a new request is taken only after the last is written back.
// After reset the block sweeps the memory to clear the valid marks and stays busy while it
// does so. The capacity register may be written at any time the block is not busy; a put
// to a new key evicts the entry with the lowest use count (smallest signed key on a tie)
// once occupancy reaches the capacity.
module lfu_key_value_cache #(
	parameter int ENTRIES = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  lfu_kvc_pkg::req_t                      request,
	output logic                                   done,
	output lfu_kvc_pkg::rsp_t                      response,
	input  logic                                   cfg_wr_en,
	input  logic [lfu_kvc_pkg::CAP_W-1:0]          cfg_wr_data
);

	import lfu_kvc_pkg::*;

	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ENT_SAT = (ENTRIES > 31) ? 31 : ENTRIES;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [CAP_W-1:0] ENT_CAP  = CAP_W'(ENT_SAT);

	state_t state_q, state_d;

	logic [CAP_W-1:0] cap_q;
	logic [OCC_W-1:0] occ_q;
	logic [IDX_W-1:0] clr_q;
	req_t             req_q;

	logic [IDX_W-1:0] rd_idx_q;
	logic             issue_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	logic                    match_q;
	logic [IDX_W-1:0]        m_idx_q;
	logic signed [VAL_W-1:0] m_val_q;
	logic [CNT_W-1:0]        m_cnt_q;

	logic                    vic_q;
	logic [IDX_W-1:0]        v_idx_q;
	logic signed [KEY_W-1:0] v_key_q;
	logic [CNT_W-1:0]        v_cnt_q;

	logic             free_q;
	logic [IDX_W-1:0] f_idx_q;

	logic             done_q;
	rsp_t             rsp_q;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic             mem_re;
	entry_t           mem_rdata;

	logic             accept;
	logic             scan_last;
	logic [CAP_W-1:0] cap_eff;
	logic             do_put;
	logic             full;
	logic             use_vic;
	logic             use_free;
	logic [CNT_W-1:0] bumped;
	rsp_t             rsp_d;

	lfu_kvc_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(ENTRIES),
		.AW   (IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(rd_idx_q),
		.rdata(mem_rdata)
	);

	assign accept    = start && (state_q == ST_IDLE);
	assign scan_last = vld_s1 && (idx_s1 == LAST_IDX);

	assign cap_eff  = (cap_q > ENT_CAP) ? ENT_CAP : cap_q;
	assign do_put   = (req_q.opcode == OP_PUT) && (cap_eff != '0);
	assign full     = CAP_W'(occ_q) >= cap_eff;
	assign use_vic  = do_put && !match_q && full && vic_q;
	assign use_free = do_put && !match_q && !use_vic && free_q;
	assign bumped   = (m_cnt_q == COUNT_MAX) ? m_cnt_q : m_cnt_q + COUNT_ONE;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		rsp_d.hit         = match_q;
		rsp_d.read_value  = ((req_q.opcode == OP_GET) && match_q) ? m_val_q : MISS_VALUE;
		rsp_d.evicted     = use_vic;
		rsp_d.evicted_key = use_vic ? v_key_q : '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_SCAN: begin
				mem_re = issue_q;
			end
			ST_WRITE: begin
				mem_wdata.valid = 1'b1;
				mem_wdata.key   = req_q.lookup_key;
				if (match_q) begin
					mem_we          = (req_q.opcode == OP_GET) || do_put;
					mem_waddr       = m_idx_q;
					mem_wdata.value = do_put ? req_q.store_value : m_val_q;
					mem_wdata.count = bumped;
				end else begin
					mem_we          = use_vic || use_free;
					mem_waddr       = use_vic ? v_idx_q : f_idx_q;
					mem_wdata.value = req_q.store_value;
					mem_wdata.count = COUNT_ONE;
				end
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			cap_q    <= CAP_RESET;
			occ_q    <= '0;
			clr_q    <= '0;
			issue_q  <= 1'b0;
			vld_s1   <= 1'b0;
			match_q  <= 1'b0;
			vic_q    <= 1'b0;
			free_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_WRITE);
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (accept) begin
				issue_q <= 1'b1;
				vld_s1  <= 1'b0;
				match_q <= 1'b0;
				vic_q   <= 1'b0;
				free_q  <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				vld_s1 <= issue_q;
				if (issue_q && (rd_idx_q == LAST_IDX)) begin
					issue_q <= 1'b0;
				end
				if (vld_s1) begin
					if (mem_rdata.valid && (mem_rdata.key == req_q.lookup_key) && !match_q) begin
						match_q <= 1'b1;
					end
					if (mem_rdata.valid && (!vic_q || (mem_rdata.count < v_cnt_q) ||
						((mem_rdata.count == v_cnt_q) && (mem_rdata.key < v_key_q)))) begin
						vic_q <= 1'b1;
					end
					if (!mem_rdata.valid && !free_q) begin
						free_q <= 1'b1;
					end
				end
			end else begin
				vld_s1 <= 1'b0;
			end
			if (use_free && (state_q == ST_WRITE)) begin
				occ_q <= occ_q + OCC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= request;
			rd_idx_q <= '0;
		end else if ((state_q == ST_SCAN) && issue_q && (rd_idx_q != LAST_IDX)) begin
			rd_idx_q <= rd_idx_q + IDX_W'(1);
		end
		if (state_q == ST_SCAN) begin
			idx_s1 <= rd_idx_q;
		end
		if ((state_q == ST_SCAN) && vld_s1) begin
			if (mem_rdata.valid && (mem_rdata.key == req_q.lookup_key) && !match_q) begin
				m_idx_q <= idx_s1;
				m_val_q <= mem_rdata.value;
				m_cnt_q <= mem_rdata.count;
			end
			if (mem_rdata.valid && (!vic_q || (mem_rdata.count < v_cnt_q) ||
				((mem_rdata.count == v_cnt_q) && (mem_rdata.key < v_key_q)))) begin
				v_idx_q <= idx_s1;
				v_key_q <= mem_rdata.key;
				v_cnt_q <= mem_rdata.count;
			end
			if (!mem_rdata.valid && !free_q) begin
				f_idx_q <= idx_s1;
			end
		end
		if (state_q == ST_WRITE) begin
			rsp_q <= rsp_d;
		end
	end

	assign done     = done_q;
	assign response = rsp_q;

`ifndef SYNTHESIS
	a_done_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_WRITE))
		else $error("done without a write-back cycle");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(occ_q) <= ENTRIES)
		else $error("occupancy exceeds the number of slots");

	a_we_window: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_WRITE))
		else $error("memory write outside clear or write-back");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted without going busy");

	a_no_evict_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && match_q) |-> !use_vic && !use_free)
		else $error("insert chosen on a hit");
`endif

endmodule
